// File: hw/rtl/pse_pkg.sv
// Shared types, constants and helpers for the postfix stack evaluator.
// No dependencies; used by postfix_stack_evaluator_unit.
package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic signed [7:0] data_t;
  typedef logic [7:0]        byte_t;

  localparam byte_t CH_ZERO   = 8'd48;
  localparam byte_t CH_PLUS   = 8'd43;
  localparam byte_t CH_MINUS  = 8'd45;
  localparam byte_t CH_TIMES  = 8'd42;
  localparam byte_t CH_DIVIDE = 8'd47;

  localparam data_t EMPTY_VALUE = -8'sd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  // Keep only the first error of an expression.
  function automatic status_t note_err(status_t cur, logic hit, status_t code);
    note_err = (cur == ST_OK && hit) ? code : cur;
  endfunction

  function automatic logic is_op(byte_t s);
    is_op = (s == CH_PLUS) || (s == CH_MINUS) || (s == CH_TIMES) || (s == CH_DIVIDE);
  endfunction

endpackage

// File: hw/rtl/postfix_stack_evaluator_unit.sv
// Postfix expression evaluator: cached top of stack plus a synchronous stack RAM,
// with a radix-2 iterative divider. Depends on pse_pkg.
//
//   channel | signals                              | dir | moves
//   --------+--------------------------------------+-----+-----------------------------
//   request | req_valid, req_ready, symbol, is_last| in  | one expression character
//   result  | res_valid, res_ready, value, status  | out | popped top and first error
//
// Steps: an operand is taken at once; + - * add an operator state (one RAM read of
// the entry under the cached top); / also adds 8 divider steps, the last writes the top.
// A character marked last adds a pop state, and a refill from RAM when entries remain.
// Reset clears the count, the error and the control; the RAM is never cleared,
// only entries below the count are read.
// The final pop waits while the result register still holds an untaken result.
module postfix_stack_evaluator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [7:0]          symbol,
  input  logic                is_last,
  output logic                res_valid,
  input  logic                res_ready,
  output logic signed [7:0]   value,
  output logic [1:0]          status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPER,
    S_DIV,
    S_POP,
    S_REFILL
  } state_t;

  state_t                    state;
  logic [pse_pkg::CNT_W-1:0] count;
  pse_pkg::data_t            top;
  pse_pkg::status_t          err;
  pse_pkg::byte_t            sym_q;
  logic                      last_q;

  // stack RAM holds every entry below the cached top
  logic [7:0]                mem [pse_pkg::STACK_DEPTH];
  pse_pkg::data_t            rdata;
  logic                      mem_we;
  logic                      mem_re;
  logic [pse_pkg::CNT_W-1:0] cnt_m1;
  logic [pse_pkg::CNT_W-1:0] cnt_m2;
  logic [pse_pkg::ADDR_W-1:0] wr_addr;
  logic [pse_pkg::ADDR_W-1:0] rd_addr;

  // divider
  logic [7:0]                div_rem;
  logic [7:0]                div_quo;
  logic [7:0]                div_den;
  logic [2:0]                div_cnt;
  logic                      div_neg;
  logic [8:0]                div_shift;
  logic [8:0]                div_diff;
  logic                      div_ge;
  logic [7:0]                div_rem_next;
  logic [7:0]                div_quo_next;
  pse_pkg::data_t            div_result;

  logic                      req_accept;
  logic                      out_free;
  logic                      has_two;
  logic                      has_one;
  logic                      cnt_full;
  pse_pkg::data_t            left;
  pse_pkg::data_t            right;
  logic [15:0]               product;
  pse_pkg::data_t            op_result;
  pse_pkg::status_t          oper_err;
  logic [pse_pkg::CNT_W-1:0] oper_count;
  logic [7:0]                left_mag;
  logic [7:0]                right_mag;

  assign req_ready  = (state == S_IDLE);
  assign req_accept = req_valid && req_ready;
  assign out_free   = !res_valid || res_ready;

  assign has_two  = (count >= pse_pkg::CNT_W'(2));
  assign has_one  = (count != '0);
  assign cnt_full = (count == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));

  assign cnt_m1  = count - pse_pkg::CNT_W'(1);
  assign cnt_m2  = count - pse_pkg::CNT_W'(2);
  assign wr_addr = cnt_m1[pse_pkg::ADDR_W-1:0];
  assign rd_addr = cnt_m2[pse_pkg::ADDR_W-1:0];

  // spill the cached top on a push; fetch the entry under it for an operator or a refill
  assign mem_we = req_accept && !pse_pkg::is_op(symbol) && has_one && !cnt_full;
  assign mem_re = has_two && ((req_accept && pse_pkg::is_op(symbol)) ||
                              (state == S_POP && out_free));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= top;
    end
    if (mem_re) begin
      rdata <= mem[rd_addr];
    end
  end

  // operands of an operator: empty pops read as -1
  assign right = has_one ? top   : pse_pkg::EMPTY_VALUE;
  assign left  = has_two ? rdata : pse_pkg::EMPTY_VALUE;

  assign product = 16'(left * right);

  always_comb begin
    case (sym_q)
      pse_pkg::CH_PLUS:  op_result = left + right;
      pse_pkg::CH_MINUS: op_result = left - right;
      pse_pkg::CH_TIMES: op_result = product[7:0];
      default:           op_result = '0;
    endcase
  end

  // pop, pop, push: the count drops by one, or lands on one from an underflow
  assign oper_count = has_two ? cnt_m1 : pse_pkg::CNT_W'(1);
  assign oper_err   = pse_pkg::note_err(
                        pse_pkg::note_err(err, !has_two, pse_pkg::ST_UNDER),
                        (sym_q == pse_pkg::CH_DIVIDE) && (right == '0),
                        pse_pkg::ST_DIVZERO);

  assign left_mag  = left[7]  ? 8'(-left)  : 8'(left);
  assign right_mag = right[7] ? 8'(-right) : 8'(right);

  // one restoring step per cycle on magnitudes
  assign div_shift    = {div_rem, div_quo[7]};
  assign div_diff     = div_shift - {1'b0, div_den};
  assign div_ge       = (div_shift >= {1'b0, div_den});
  assign div_rem_next = div_ge ? div_diff[7:0] : div_shift[7:0];
  assign div_quo_next = {div_quo[6:0], div_ge};
  assign div_result   = div_neg ? 8'(-div_quo_next) : div_quo_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= pse_pkg::ST_OK;
      res_valid <= 1'b0;
      div_cnt   <= '0;
    end else begin
      // S_POP loads a new result whenever the old one leaves
      if (res_valid && res_ready && state != S_POP) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_accept) begin
            sym_q  <= symbol;
            last_q <= is_last;
            if (pse_pkg::is_op(symbol)) begin
              state <= S_OPER;
            end else begin
              if (cnt_full) begin
                err <= pse_pkg::note_err(err, 1'b1, pse_pkg::ST_OVER);
              end else begin
                top   <= pse_pkg::data_t'(symbol - pse_pkg::CH_ZERO);
                count <= count + pse_pkg::CNT_W'(1);
              end
              state <= is_last ? S_POP : S_IDLE;
            end
          end
        end
        S_OPER: begin
          err <= oper_err;
          if (sym_q == pse_pkg::CH_DIVIDE && right != '0) begin
            div_rem <= '0;
            div_quo <= left_mag;
            div_den <= right_mag;
            div_neg <= left[7] ^ right[7];
            div_cnt <= '0;
            state   <= S_DIV;
          end else begin
            top   <= op_result;
            count <= oper_count;
            state <= last_q ? S_POP : S_IDLE;
          end
        end
        S_DIV: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            top   <= div_result;
            count <= oper_count;
            state <= last_q ? S_POP : S_IDLE;
          end
        end
        S_POP: begin
          // hold until the result register is free
          if (out_free) begin
            res_valid <= 1'b1;
            value     <= has_one ? top : pse_pkg::EMPTY_VALUE;
            status    <= pse_pkg::note_err(err, !has_one, pse_pkg::ST_UNDER);
            err       <= pse_pkg::ST_OK;
            if (has_one) begin
              count <= cnt_m1;
            end
            state <= has_two ? S_REFILL : S_IDLE;
          end
        end
        S_REFILL: begin
          top   <= rdata;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_err_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP && out_free) |=> (err == pse_pkg::ST_OK && res_valid))
    else $error("error not cleared after result");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && $past(state) != S_DIV) |-> (div_cnt == 3'd0 && div_den != '0))
    else $error("divider entered with bad step count or zero divisor");

  a_refill_src: assert property (@(posedge clk) disable iff (rst)
    (state == S_REFILL) |-> ($past(state) == S_POP && count != '0))
    else $error("top refill without a pop");

endmodule
